[sv/fdjlm_pkg.sv]
`timescale 1ns / 1ps

package fdjlm_pkg;

  localparam int CFG_IDX_W = 4;

  localparam logic [1:0] REQ_PACKET    = 2'd0;
  localparam logic [1:0] REQ_RD_DELAY  = 2'd1;
  localparam logic [1:0] REQ_RD_JITTER = 2'd2;
  localparam logic [1:0] REQ_CLEAR     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_EN    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LOW   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_WIDTH = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_BINS  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_EN    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_LOW   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_WIDTH = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_BINS  = 4'd7;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/flow_delay_jitter_loss_monitor_top.sv]
`timescale 1ns / 1ps
// channel  handshake             payload
// in       in_valid / in_ready   req_type, seq_number, packet_bytes, send_time,
//                                arrival_time, bin_select
// out      out_valid / out_ready packets_received ... jitter_mean, jitter_max, bin_value
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data (cfg_ready always high)
//
// One request at a time; in_ready is high only while the sequencer is idle.
// A packet request updates the counters, then each enabled histogram (the shared
// 64/32 divider finds the bin, except below the low bound, which goes to bin 0), then
// the delay and jitter means through the same divider, which saturates its quotient.
// Clear: a bin sweep, one entry a cycle, then the result.
// After reset the same sweep runs over all MAX_BINS entries before in_ready rises.
// A waiting result does not block acceptance; it only holds the final step.

module flow_delay_jitter_loss_monitor_top #(
  parameter int MAX_BINS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         req_type,
  input  logic [30:0]                        seq_number,
  input  logic [15:0]                        packet_bytes,
  input  logic [31:0]                        send_time,
  input  logic [31:0]                        arrival_time,
  input  logic [5:0]                         bin_select,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [31:0]                        packets_received,
  output logic [47:0]                        bytes_received,
  output logic [31:0]                        packets_lost,
  output logic [31:0]                        delay_mean,
  output logic [31:0]                        delay_max,
  output logic [31:0]                        jitter_mean,
  output logic [31:0]                        jitter_max,
  output logic [31:0]                        bin_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fdjlm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                        cfg_data
);

  import fdjlm_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BINS - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLR      = 4'd1;
  localparam logic [3:0] S_PKT      = 4'd2;
  localparam logic [3:0] S_JIT      = 4'd3;
  localparam logic [3:0] S_BIN_CHK  = 4'd4;
  localparam logic [3:0] S_BIN_WAIT = 4'd5;
  localparam logic [3:0] S_BIN_RD   = 4'd6;
  localparam logic [3:0] S_BIN_WR   = 4'd7;
  localparam logic [3:0] S_MD       = 4'd8;
  localparam logic [3:0] S_MD_WAIT  = 4'd9;
  localparam logic [3:0] S_MJ       = 4'd10;
  localparam logic [3:0] S_MJ_WAIT  = 4'd11;
  localparam logic [3:0] S_RD_WAIT  = 4'd12;
  localparam logic [3:0] S_RD_TAKE  = 4'd13;
  localparam logic [3:0] S_FIN      = 4'd14;

  // configuration
  logic        delay_en;
  logic [31:0] delay_low;
  logic [31:0] delay_width;
  logic [6:0]  delay_bins;
  logic        jitter_en;
  logic [31:0] jitter_low;
  logic [31:0] jitter_width;
  logic [6:0]  jitter_bins;

  // statistics
  logic [31:0] expected_seq;
  logic        expected_valid;
  logic [31:0] packet_cnt;
  logic [47:0] byte_cnt;
  logic [31:0] lost_cnt;
  logic [63:0] delay_total;
  logic [31:0] delay_peak;
  logic [31:0] prev_delay;
  logic        prev_valid;
  logic [63:0] jitter_total;
  logic [31:0] jitter_peak;
  logic [31:0] dmean;
  logic [31:0] jmean;

  // request in flight
  logic [3:0]    state;
  logic [1:0]    req_q;
  logic [30:0]   seq_q;
  logic [15:0]   bytes_q;
  logic [31:0]   d;
  logic [31:0]   j;
  logic          jit_take;
  logic          sel_ok;
  logic [31:0]   bin;
  logic          hsel;
  logic          clr_reply;
  logic [AW-1:0] ram_addr;

  // divider
  logic        div_start;
  logic [63:0] div_dividend;
  logic [31:0] div_divisor;
  div_stat_t   div_stat;
  logic [31:0] div_q;

  // histogram memories
  logic        dh_we;
  logic        jh_we;
  logic [31:0] dh_rdata;
  logic [31:0] jh_rdata;
  logic [31:0] dh_wdata;
  logic [31:0] jh_wdata;

  // helpers
  logic [31:0] sel_ext;
  logic        sel_in_range;
  logic [AW-1:0] sel_addr;
  logic [48:0] byte_sum;
  logic [31:0] lost_gap;
  logic [32:0] lost_sum;
  logic [64:0] dtot_sum;
  logic [64:0] jtot_sum;
  logic [31:0] j_calc;
  logic        h_en;
  logic [31:0] h_val;
  logic [31:0] h_low;
  logic [31:0] h_width;
  logic [31:0] h_bins;
  logic [31:0] idx32;

  function automatic logic [31:0] bins_eff(input logic [6:0] used);
    logic [31:0] u;
    u = 32'(used);
    if (u == 32'd0) begin
      bins_eff = 32'd1;
    end else if (u > 32'(MAX_BINS)) begin
      bins_eff = 32'(MAX_BINS);
    end else begin
      bins_eff = u;
    end
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == '1) ? v : v + 32'd1;
  endfunction

  assign in_ready  = state == S_IDLE;
  assign cfg_ready = 1'b1;

  always_comb begin
    sel_ext      = 32'(bin_select);
    sel_in_range = sel_ext < 32'(MAX_BINS);
    sel_addr     = sel_ext[AW-1:0];

    byte_sum = {1'b0, byte_cnt} + 49'(bytes_q);
    lost_gap = {1'b0, seq_q} - expected_seq;
    lost_sum = {1'b0, lost_cnt} + {1'b0, lost_gap};
    dtot_sum = {1'b0, delay_total} + 65'(d);
    jtot_sum = {1'b0, jitter_total} + 65'(j);
    j_calc   = (d > prev_delay) ? d - prev_delay : prev_delay - d;

    h_en    = hsel ? (jitter_en & jit_take) : delay_en;
    h_val   = hsel ? j : d;
    h_low   = hsel ? jitter_low : delay_low;
    h_width = hsel ? jitter_width : delay_width;
    if (h_width == 32'd0) begin
      h_width = 32'd1;
    end
    h_bins = hsel ? bins_eff(jitter_bins) : bins_eff(delay_bins);
    idx32  = (div_q >= h_bins) ? h_bins - 32'd1 : div_q;

    div_start    = 1'b0;
    div_dividend = {delay_total};
    div_divisor  = packet_cnt;
    case (state)
      S_BIN_CHK: begin
        div_start    = h_en && (h_val >= h_low);
        div_dividend = {32'd0, h_val - h_low};
        div_divisor  = h_width;
      end
      S_MD: begin
        div_start = 1'b1;
      end
      S_MJ: begin
        div_start    = packet_cnt > 32'd1;
        div_dividend = jitter_total;
        div_divisor  = packet_cnt - 32'd1;
      end
      default: begin
      end
    endcase

    dh_we    = (state == S_CLR) || (state == S_BIN_WR && !hsel);
    jh_we    = (state == S_CLR) || (state == S_BIN_WR && hsel);
    dh_wdata = (state == S_CLR) ? 32'd0 : sat_inc(dh_rdata);
    jh_wdata = (state == S_CLR) ? 32'd0 : sat_inc(jh_rdata);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_en     <= 1'b0;
      delay_low    <= '0;
      delay_width  <= 32'd1;
      delay_bins   <= 7'd64;
      jitter_en    <= 1'b0;
      jitter_low   <= '0;
      jitter_width <= 32'd1;
      jitter_bins  <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DELAY_EN:     delay_en     <= cfg_data[0];
        CFG_DELAY_LOW:    delay_low    <= cfg_data;
        CFG_DELAY_WIDTH:  delay_width  <= cfg_data;
        CFG_DELAY_BINS:   delay_bins   <= cfg_data[6:0];
        CFG_JITTER_EN:    jitter_en    <= cfg_data[0];
        CFG_JITTER_LOW:   jitter_low   <= cfg_data;
        CFG_JITTER_WIDTH: jitter_width <= cfg_data;
        CFG_JITTER_BINS:  jitter_bins  <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      ram_addr       <= '0;
      clr_reply      <= 1'b0;
      hsel           <= 1'b0;
      jit_take       <= 1'b0;
      out_valid      <= 1'b0;
      expected_seq   <= '0;
      expected_valid <= 1'b0;
      packet_cnt     <= '0;
      byte_cnt       <= '0;
      lost_cnt       <= '0;
      delay_total    <= '0;
      delay_peak     <= '0;
      prev_delay     <= '0;
      prev_valid     <= 1'b0;
      jitter_total   <= '0;
      jitter_peak    <= '0;
      dmean          <= '0;
      jmean          <= '0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_q    <= req_type;
            seq_q    <= seq_number;
            bytes_q  <= packet_bytes;
            d        <= (arrival_time > send_time) ? arrival_time - send_time : 32'd0;
            sel_ok   <= sel_in_range;
            ram_addr <= (req_type == REQ_CLEAR) ? '0 : sel_addr;
            bin      <= '0;
            case (req_type)
              REQ_PACKET:                 state <= S_PKT;
              REQ_RD_DELAY, REQ_RD_JITTER: state <= S_RD_WAIT;
              default: begin
                expected_seq   <= '0;
                expected_valid <= 1'b0;
                packet_cnt     <= '0;
                byte_cnt       <= '0;
                lost_cnt       <= '0;
                delay_total    <= '0;
                delay_peak     <= '0;
                prev_delay     <= '0;
                prev_valid     <= 1'b0;
                jitter_total   <= '0;
                jitter_peak    <= '0;
                dmean          <= '0;
                jmean          <= '0;
                clr_reply      <= 1'b1;
                state          <= S_CLR;
              end
            endcase
          end
        end
        S_CLR: begin
          if (ram_addr == LAST_ADDR) begin
            ram_addr <= '0;
            state    <= clr_reply ? S_FIN : S_IDLE;
          end else begin
            ram_addr <= ram_addr + AW'(1);
          end
        end
        S_PKT: begin
          byte_cnt   <= byte_sum[48] ? '1 : byte_sum[47:0];
          packet_cnt <= (packet_cnt == '1) ? packet_cnt : packet_cnt + 32'd1;
          if (expected_valid && ({1'b0, seq_q} > expected_seq)) begin
            lost_cnt <= lost_sum[32] ? '1 : lost_sum[31:0];
          end
          expected_seq   <= {1'b0, seq_q} + 32'd1;
          expected_valid <= 1'b1;
          delay_total    <= dtot_sum[64] ? '1 : dtot_sum[63:0];
          if (d > delay_peak) begin
            delay_peak <= d;
          end
          // count after this beat exceeds one exactly when it was nonzero
          jit_take   <= prev_valid && (prev_delay != 32'd0) && (packet_cnt != 32'd0);
          j          <= j_calc;
          prev_delay <= d;
          prev_valid <= 1'b1;
          state      <= S_JIT;
        end
        S_JIT: begin
          if (jit_take) begin
            jitter_total <= jtot_sum[64] ? '1 : jtot_sum[63:0];
            if (j > jitter_peak) begin
              jitter_peak <= j;
            end
          end
          hsel  <= 1'b0;
          state <= S_BIN_CHK;
        end
        S_BIN_CHK: begin
          if (!h_en) begin
            hsel  <= 1'b1;
            state <= hsel ? S_MD : S_BIN_CHK;
          end else if (h_val < h_low) begin
            ram_addr <= '0;
            state    <= S_BIN_RD;
          end else begin
            state <= S_BIN_WAIT;
          end
        end
        S_BIN_WAIT: begin
          if (div_stat.done) begin
            ram_addr <= idx32[AW-1:0];
            state    <= S_BIN_RD;
          end
        end
        S_BIN_RD: state <= S_BIN_WR;
        S_BIN_WR: begin
          hsel  <= 1'b1;
          state <= hsel ? S_MD : S_BIN_CHK;
        end
        S_MD: state <= S_MD_WAIT;
        S_MD_WAIT: begin
          if (div_stat.done) begin
            dmean <= div_q;
            state <= S_MJ;
          end
        end
        S_MJ: begin
          if (packet_cnt > 32'd1) begin
            state <= S_MJ_WAIT;
          end else begin
            jmean <= '0;
            state <= S_FIN;
          end
        end
        S_MJ_WAIT: begin
          if (div_stat.done) begin
            jmean <= div_q;
            state <= S_FIN;
          end
        end
        S_RD_WAIT: state <= S_RD_TAKE;
        S_RD_TAKE: begin
          if (sel_ok) begin
            bin <= (req_q == REQ_RD_DELAY) ? dh_rdata : jh_rdata;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            packets_received <= packet_cnt;
            bytes_received   <= byte_cnt;
            packets_lost     <= lost_cnt;
            delay_mean       <= dmean;
            delay_max        <= delay_peak;
            jitter_mean      <= jmean;
            jitter_max       <= jitter_peak;
            bin_value        <= bin;
            out_valid        <= 1'b1;
            clr_reply        <= 1'b0;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  fdjlm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  fdjlm_ram #(
    .WIDTH (32),
    .DEPTH (MAX_BINS)
  ) u_delay_hist (
    .clk   (clk),
    .we    (dh_we),
    .waddr (ram_addr),
    .wdata (dh_wdata),
    .raddr (ram_addr),
    .rdata (dh_rdata)
  );

  fdjlm_ram #(
    .WIDTH (32),
    .DEPTH (MAX_BINS)
  ) u_jitter_hist (
    .clk   (clk),
    .we    (jh_we),
    .waddr (ram_addr),
    .wdata (jh_wdata),
    .raddr (ram_addr),
    .rdata (jh_rdata)
  );

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_BIN_WAIT || state == S_MD_WAIT || state == S_MJ_WAIT))
    else $error("quotient ready with no state waiting for it");

  a_bin_addr_range: assert property (@(posedge clk) disable iff (rst)
    (dh_we || jh_we) |-> (32'(ram_addr) < 32'(MAX_BINS)))
    else $error("histogram write beyond last bin");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && req_type == REQ_CLEAR) |=>
      (packet_cnt == '0 && delay_total == '0 && jitter_total == '0 && state == S_CLR))
    else $error("clear beat left counters nonzero");

endmodule

[sv/fdjlm_ram.sv]
`timescale 1ns / 1ps

module fdjlm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/fdjlm_div.sv]
`timescale 1ns / 1ps

module fdjlm_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          dividend,
  input  logic [31:0]          divisor,
  output fdjlm_pkg::div_stat_t stat,
  output logic [31:0]          quotient
);

  import fdjlm_pkg::*;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_CHK  = 2'd1;
  localparam logic [1:0] D_RUN  = 2'd2;

  logic [1:0]  dstate;
  logic [31:0] rem;
  logic [31:0] lo;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic        done;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        qbit;
  logic [31:0] rem_next;

  // restoring step, one quotient bit per cycle; rem < dvs holds while running
  always_comb begin
    trial    = {rem, lo[31]};
    diff     = trial - {1'b0, dvs};
    qbit     = trial >= {1'b0, dvs};
    rem_next = qbit ? diff[31:0] : trial[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      case (dstate)
        D_IDLE: begin
          done <= 1'b0;
          if (start) begin
            rem    <= dividend[63:32];
            lo     <= dividend[31:0];
            dvs    <= divisor;
            cnt    <= '0;
            dstate <= D_CHK;
          end
        end
        D_CHK: begin
          // quotient would not fit in 32 bits: saturate
          done <= rem >= dvs;
          if (rem >= dvs) begin
            lo     <= '1;
            dstate <= D_IDLE;
          end else begin
            dstate <= D_RUN;
          end
        end
        D_RUN: begin
          rem  <= rem_next;
          lo   <= {lo[30:0], qbit};
          cnt  <= cnt + 5'd1;
          done <= cnt == 5'd31;
          if (cnt == 5'd31) begin
            dstate <= D_IDLE;
          end
        end
        default: begin
          done   <= 1'b0;
          dstate <= D_IDLE;
        end
      endcase
    end
  end

  assign stat.busy = dstate != D_IDLE;
  assign stat.done = done;
  assign quotient  = lo;

endmodule

[bench/flow_delay_jitter_loss_monitor_top_tb.sv]
`timescale 1ns / 1ps

module flow_delay_jitter_loss_monitor_top_tb;
  import fdjlm_pkg::*;

  localparam int NUM_BINS = 64;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [63:0] M32 = 64'hFFFF_FFFF;
  localparam logic [63:0] M48 = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] M64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] packets_received;
    logic [47:0] bytes_received;
    logic [31:0] packets_lost;
    logic [31:0] delay_mean;
    logic [31:0] delay_max;
    logic [31:0] jitter_mean;
    logic [31:0] jitter_max;
    logic [31:0] bin_value;
  } stats_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = REQ_PACKET;
  logic [30:0] seq_number = '0;
  logic [15:0] packet_bytes = '0;
  logic [31:0] send_time = '0;
  logic [31:0] arrival_time = '0;
  logic [5:0]  bin_select = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [31:0] packets_received;
  logic [47:0] bytes_received;
  logic [31:0] packets_lost;
  logic [31:0] delay_mean;
  logic [31:0] delay_max;
  logic [31:0] jitter_mean;
  logic [31:0] jitter_max;
  logic [31:0] bin_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // register copies
  logic        dly_en, jit_en;
  logic [31:0] dly_low, dly_width, jit_low, jit_width;
  logic [6:0]  dly_used, jit_used;

  // flow statistics
  logic [31:0] next_seq;
  logic        seq_seen;
  logic [31:0] pkt_cnt, lost_cnt, delay_top, last_delay, jit_top;
  logic [47:0] byte_cnt;
  logic [63:0] delay_sum, jit_sum;
  logic        last_delay_ok;
  logic [31:0] delay_hist [NUM_BINS];
  logic [31:0] jitter_hist [NUM_BINS];

  stats_t      stats_queue [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          idle_en = 1'b1;
  logic [30:0] seq_cursor = '0;

  flow_delay_jitter_loss_monitor_top #(.MAX_BINS(NUM_BINS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .seq_number(seq_number), .packet_bytes(packet_bytes),
    .send_time(send_time), .arrival_time(arrival_time), .bin_select(bin_select),
    .out_valid(out_valid), .out_ready(out_ready),
    .packets_received(packets_received), .bytes_received(bytes_received),
    .packets_lost(packets_lost), .delay_mean(delay_mean), .delay_max(delay_max),
    .jitter_mean(jitter_mean), .jitter_max(jitter_max), .bin_value(bin_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
    if (a >= lim || b > lim - a) return lim;
    return a + b;
  endfunction

  function automatic int unsigned bin_index(logic [31:0] v, logic [31:0] low,
                                            logic [31:0] width, logic [6:0] used);
    logic [31:0] n, w, idx;
    n = (used == 0) ? 32'd1 : {25'd0, used};
    if (n > NUM_BINS) n = NUM_BINS;
    w = (width == 0) ? 32'd1 : width;
    idx = (v >= low) ? (v - low) / w : 32'd0;
    if (idx >= n) idx = n - 32'd1;
    return idx;
  endfunction

  function automatic void wipe_stats();
    next_seq = '0;
    seq_seen = 1'b0;
    pkt_cnt = '0;
    byte_cnt = '0;
    lost_cnt = '0;
    delay_sum = '0;
    delay_top = '0;
    last_delay = '0;
    last_delay_ok = 1'b0;
    jit_sum = '0;
    jit_top = '0;
    foreach (delay_hist[i]) delay_hist[i] = '0;
    foreach (jitter_hist[i]) jitter_hist[i] = '0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      CFG_DELAY_EN:     dly_en = data[0];
      CFG_DELAY_LOW:    dly_low = data;
      CFG_DELAY_WIDTH:  dly_width = data;
      CFG_DELAY_BINS:   dly_used = data[6:0];
      CFG_JITTER_EN:    jit_en = data[0];
      CFG_JITTER_LOW:   jit_low = data;
      CFG_JITTER_WIDTH: jit_width = data;
      CFG_JITTER_BINS:  jit_used = data[6:0];
      default: ;
    endcase
  endfunction

  function automatic stats_t compute_stats(logic [1:0] rt, logic [30:0] seq, logic [15:0] nb,
                                           logic [31:0] ts, logic [31:0] ta, logic [5:0] sel);
    stats_t s;
    logic [31:0] d, j;
    logic [63:0] dm, jm;
    int unsigned k;
    s = '0;
    if (rt == REQ_PACKET) begin
      d = (ta > ts) ? ta - ts : 32'd0;
      byte_cnt = 48'(sat_add(byte_cnt, nb, M48));
      pkt_cnt = 32'(sat_add(pkt_cnt, 64'd1, M32));
      if (seq_seen && {1'b0, seq} > next_seq)
        lost_cnt = 32'(sat_add(lost_cnt, {1'b0, seq} - next_seq, M32));
      next_seq = {1'b0, seq} + 32'd1;
      seq_seen = 1'b1;
      delay_sum = sat_add(delay_sum, d, M64);
      if (dly_en) begin
        k = bin_index(d, dly_low, dly_width, dly_used);
        if (delay_hist[k] != 32'hFFFF_FFFF) delay_hist[k] = delay_hist[k] + 32'd1;
      end
      if (d > delay_top) delay_top = d;
      // jitter only against a positive previous delay
      if (last_delay_ok && last_delay != 0 && pkt_cnt > 1) begin
        j = (d > last_delay) ? d - last_delay : last_delay - d;
        jit_sum = sat_add(jit_sum, j, M64);
        if (j > jit_top) jit_top = j;
        if (jit_en) begin
          k = bin_index(j, jit_low, jit_width, jit_used);
          if (jitter_hist[k] != 32'hFFFF_FFFF) jitter_hist[k] = jitter_hist[k] + 32'd1;
        end
      end
      last_delay = d;
      last_delay_ok = 1'b1;
    end else if (rt == REQ_RD_DELAY) begin
      s.bin_value = delay_hist[sel];
    end else if (rt == REQ_RD_JITTER) begin
      s.bin_value = jitter_hist[sel];
    end else begin
      wipe_stats();
    end
    dm = (pkt_cnt > 0) ? delay_sum / {32'd0, pkt_cnt} : 64'd0;
    jm = (pkt_cnt > 1) ? jit_sum / {32'd0, pkt_cnt - 32'd1} : 64'd0;
    s.packets_received = pkt_cnt;
    s.bytes_received = byte_cnt;
    s.packets_lost = lost_cnt;
    s.delay_mean = (dm > M32) ? 32'hFFFF_FFFF : dm[31:0];
    s.delay_max = delay_top;
    s.jitter_mean = (jm > M32) ? 32'hFFFF_FFFF : jm[31:0];
    s.jitter_max = jit_top;
    return s;
  endfunction

  function automatic logic [31:0] zone_value(logic [31:0] low, logic [31:0] width,
                                             logic [6:0] used);
    logic [63:0] base, span, v;
    base = (low > width) ? {32'd0, low - width} : 64'd0;
    span = {32'd0, width} * {57'd0, used + 7'd3};
    if (span > M32) span = M32;
    v = base + $urandom_range(0, span[31:0]);
    if (v > M32) v = M32;
    return v[31:0];
  endfunction

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    stats_t want;
    if (stats_queue.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: result beat with nothing pending", $time);
      return;
    end
    want = stats_queue.pop_front();
    check_field("packets_received", want.packets_received, packets_received);
    check_field("bytes_received", want.bytes_received, bytes_received);
    check_field("packets_lost", want.packets_lost, packets_lost);
    check_field("delay_mean", want.delay_mean, delay_mean);
    check_field("delay_max", want.delay_max, delay_max);
    check_field("jitter_mean", want.jitter_mean, jitter_mean);
    check_field("jitter_max", want.jitter_max, jitter_max);
    check_field("bin_value", want.bin_value, bin_value);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_ready <= 1'b1;
    end else if (idle_en && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 16);
      out_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] rt, input logic [30:0] seq, input logic [15:0] nb,
                          input logic [31:0] ts, input logic [31:0] ta, input logic [5:0] sel);
    in_valid <= 1'b1;
    req_type <= rt;
    seq_number <= seq;
    packet_bytes <= nb;
    send_time <= ts;
    arrival_time <= ta;
    bin_select <= sel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    stats_queue.push_back(compute_stats(rt, seq, nb, ts, ta, sel));
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (stats_queue.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic de, input logic [31:0] dl, input logic [31:0] dw,
                              input logic [6:0] db, input logic je, input logic [31:0] jl,
                              input logic [31:0] jw, input logic [6:0] jb);
    logic [CFG_IDX_W-1:0] idx [8];
    logic [31:0] val [8];
    int i;
    idx = '{CFG_DELAY_EN, CFG_DELAY_LOW, CFG_DELAY_WIDTH, CFG_DELAY_BINS,
            CFG_JITTER_EN, CFG_JITTER_LOW, CFG_JITTER_WIDTH, CFG_JITTER_BINS};
    val = '{{31'd0, de}, dl, dw, {25'd0, db}, {31'd0, je}, jl, jw, {25'd0, jb}};
    drain();
    for (i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_traffic(input int count);
    int r, k;
    int unsigned used;
    logic [1:0]  rt;
    logic [15:0] nb;
    logic [31:0] ts, ta, d, j;
    logic [63:0] sum;
    logic [5:0]  sel;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      rt = (r < 70) ? REQ_PACKET : (r < 84) ? REQ_RD_DELAY : (r < 98) ? REQ_RD_JITTER : REQ_CLEAR;
      ts = $urandom;
      ta = $urandom;
      nb = 16'($urandom);
      used = (rt == REQ_RD_JITTER) ? jit_used : dly_used;
      if (used == 0) used = 1;
      if (used > NUM_BINS) used = NUM_BINS;
      sel = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, used - 1)) : 6'($urandom);
      if (rt == REQ_PACKET) begin
        r = $urandom_range(0, 99);
        if (r < 80) seq_cursor = seq_cursor + 31'd1;
        else if (r < 90) seq_cursor = seq_cursor + 31'($urandom_range(2, 40));
        else if (r < 96) seq_cursor = seq_cursor - 31'($urandom_range(0, 5));
        else seq_cursor = 31'($urandom);
        r = $urandom_range(0, 99);
        if (r < 5) nb = 16'hFFFF;
        else if (r < 10) nb = 16'h0000;
        r = $urandom_range(0, 99);
        if (r < 90) begin
          if (r < 45) begin
            d = zone_value(dly_low, dly_width, dly_used);
          end else begin
            // aim the step from the last delay at the jitter bins
            j = zone_value(jit_low, jit_width, jit_used);
            if ($urandom_range(0, 1) == 1) begin
              sum = {32'd0, last_delay} + {32'd0, j};
              d = (sum > M32) ? 32'hFFFF_FFFF : sum[31:0];
            end else begin
              d = (last_delay > j) ? last_delay - j : 32'd0;
            end
          end
          ts = $urandom_range(0, 32'hFFFF_FFFF - d);
          ta = ts + d;
        end else if (r < 95) begin
          ta = $urandom_range(0, ts);
        end
      end
      send_req(rt, seq_cursor, nb, ts, ta, sel);
    end
  endtask

  task automatic test_directed();
    program_regs(1'b1, 32'd100, 32'd10, 7'd8, 1'b1, 32'd0, 32'd5, 7'd4);
    send_req(REQ_RD_DELAY, 31'd0, 16'd0, 32'd0, 32'd0, 6'd0);
    send_req(REQ_RD_JITTER, 31'd0, 16'd0, 32'd0, 32'd0, 6'd63);
    send_req(REQ_PACKET, 31'd10, 16'd0, 32'd1000, 32'd1150, 6'd0);
    send_req(REQ_PACKET, 31'd11, 16'hFFFF, 32'd0, 32'd0, 6'd0);
    send_req(REQ_PACKET, 31'd12, 16'd1, 32'd500, 32'd550, 6'd0);
    send_req(REQ_PACKET, 31'd20, 16'd64, 32'd7, 32'd67, 6'd0);
    send_req(REQ_PACKET, 31'd15, 16'd64, 32'hFFFF_FFFF, 32'd0, 6'd0);
    send_req(REQ_PACKET, 31'd15, 16'd64, 32'd0, 32'hFFFF_FFFF, 6'd0);
    send_req(REQ_PACKET, 31'h7FFF_FFFF, 16'd2, 32'd1, 32'd2, 6'd0);
    send_req(REQ_PACKET, 31'd0, 16'd3, 32'd123, 32'd123, 6'd0);
    send_req(REQ_RD_DELAY, 31'd0, 16'd0, 32'd0, 32'd0, 6'd0);
    send_req(REQ_RD_DELAY, 31'd0, 16'd0, 32'd0, 32'd0, 6'd5);
    send_req(REQ_RD_DELAY, 31'd0, 16'd0, 32'd0, 32'd0, 6'd7);
    send_req(REQ_RD_DELAY, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_req(REQ_RD_JITTER, 31'd0, 16'd0, 32'd0, 32'd0, 6'd0);
    send_req(REQ_RD_JITTER, 31'd0, 16'd0, 32'd0, 32'd0, 6'd2);
    send_req(REQ_RD_JITTER, 31'd0, 16'd0, 32'd0, 32'd0, 6'd3);
    send_req(REQ_CLEAR, 31'd0, 16'd0, 32'd0, 32'd0, 6'd0);
    send_req(REQ_RD_DELAY, 31'd0, 16'd0, 32'd0, 32'd0, 6'd5);
    send_req(REQ_RD_JITTER, 31'd0, 16'd0, 32'd0, 32'd0, 6'd3);
    send_req(REQ_PACKET, 31'd5, 16'd100, 32'd10, 32'd20, 6'd0);
    send_req(REQ_PACKET, 31'd9, 16'd100, 32'd10, 32'd35, 6'd0);
    send_req(REQ_RD_JITTER, 31'd0, 16'd0, 32'd0, 32'd0, 6'd3);
  endtask

  task automatic test_fine_bins();
    program_regs(1'b1, 32'd0, 32'd1, 7'd64, 1'b1, 32'd0, 32'd1, 7'd64);
    random_traffic(300);
  endtask

  task automatic test_coarse_bins();
    program_regs(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd1,
                 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd1);
    random_traffic(200);
  endtask

  // reads still return the stored counts while binning is off
  task automatic test_hist_off();
    program_regs(1'b0, 32'd50, 32'd20, 7'd16, 1'b0, 32'd10, 32'd7, 7'd32);
    random_traffic(200);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      program_regs(1'($urandom), $urandom_range(0, 2000), $urandom_range(1, 300),
                   7'($urandom_range(1, 64)), 1'($urandom), $urandom_range(0, 500),
                   $urandom_range(1, 300), 7'($urandom_range(1, 64)));
      random_traffic(150);
    end
  endtask

  task automatic test_back_to_back();
    program_regs(1'b1, 32'd200, 32'd25, 7'd40, 1'b1, 32'd5, 32'd3, 7'd64);
    idle_en = 1'b0;
    random_traffic(300);
  endtask

  initial begin
    dly_en = 1'b0;
    dly_low = '0;
    dly_width = 32'd1;
    dly_used = 7'd64;
    jit_en = 1'b0;
    jit_low = '0;
    jit_width = 32'd1;
    jit_used = 7'd64;
    wipe_stats();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    test_directed();
    test_fine_bins();
    test_coarse_bins();
    test_hist_off();
    test_random_settings();
    test_back_to_back();
    drain();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && stats_queue.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
